FILE: hdl/trc_pkg.sv
`default_nettype none
package trc_pkg;

	localparam int CONF_MAX_DEFAULT = 1024;
	localparam int CONF_W = 16;
	localparam int DATA_W = 32;
	localparam int RADIUS_W = 24;
	localparam int MIN_CONF_W = 16;
	// exponent argument: 4 integer bits, 16 fraction bits
	localparam int XARG_W = 20;
	localparam int EXP_W = 17;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_MIN_CONF  = 2'd1,
		REG_OFFSET    = 2'd2,
		REG_GAIN      = 2'd3
	} reg_idx_t;

	// fields that ride along the divider and exp pipelines
	typedef struct packed {
		logic [DATA_W-1:0] slip;
		logic [DATA_W-1:0] raw;
		logic              rot_zero;
		logic              tight;
	} side_t;

	// round(2^16*exp(-k/16)), k = 0..16
	function automatic logic [EXP_W-1:0] frac_tab(input logic [4:0] k);
		logic [EXP_W-1:0] v;
		case (k)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd61565;
			5'd2:    v = 17'd57835;
			5'd3:    v = 17'd54331;
			5'd4:    v = 17'd51039;
			5'd5:    v = 17'd47947;
			5'd6:    v = 17'd45042;
			5'd7:    v = 17'd42313;
			5'd8:    v = 17'd39750;
			5'd9:    v = 17'd37341;
			5'd10:   v = 17'd35079;
			5'd11:   v = 17'd32954;
			5'd12:   v = 17'd30957;
			5'd13:   v = 17'd29081;
			5'd14:   v = 17'd27319;
			5'd15:   v = 17'd25664;
			5'd16:   v = 17'd24109;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// round(2^16*exp(-n)), n = 0..11
	function automatic logic [EXP_W-1:0] int_tab(input logic [3:0] n);
		logic [EXP_W-1:0] v;
		case (n)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd24109;
			4'd2:    v = 17'd8869;
			4'd3:    v = 17'd3263;
			4'd4:    v = 17'd1200;
			4'd5:    v = 17'd442;
			4'd6:    v = 17'd162;
			4'd7:    v = 17'd60;
			4'd8:    v = 17'd22;
			4'd9:    v = 17'd8;
			4'd10:   v = 17'd3;
			4'd11:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/turn_radius_confidence_unit.sv
// throughput: one transaction per cycle, busy stays low
// two pipelined restoring dividers (radius, exp argument) and the exp table set the depth
// the receiver cannot stall; results appear on done for one cycle each
// asynchronous active-low reset clears all valid bits and restores register defaults
`default_nettype none
module turn_radius_confidence_unit #(
	parameter int CONFIDENCE_MAX = trc_pkg::CONF_MAX_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [3:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [31:0]                translation,
	input  wire logic [31:0]                rotation,
	input  wire logic [31:0]                slip_conf,
	input  wire logic [31:0]                raw_confidence,
	output logic                            done,
	output logic [31:0]                     raw_confidence_out,
	output logic [30:0]                     model_confidence,
	output logic [31:0]                     final_confidence
);
	import trc_pkg::*;

	localparam int SW = $bits(side_t);

	logic [RADIUS_W-1:0]   thresh_q, offset_q, gain_q;
	logic [MIN_CONF_W-1:0] min_conf_q;
	reg_idx_t              widx;

	assign widx   = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= '0;
			min_conf_q <= '0;
			offset_q   <= 24'd256;
			gain_q     <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_THRESHOLD: thresh_q   <= pwdata[23:0];
				REG_MIN_CONF:  min_conf_q <= pwdata[15:0];
				REG_OFFSET:    offset_q   <= pwdata[23:0];
				REG_GAIN:      gain_q     <= pwdata[23:0];
				default:       thresh_q   <= thresh_q;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_THRESHOLD: prdata = 32'(thresh_q);
			REG_MIN_CONF:  prdata = 32'(min_conf_q);
			REG_OFFSET:    prdata = 32'(offset_q);
			REG_GAIN:      prdata = 32'(gain_q);
			default:       prdata = '0;
		endcase
	end

	// s1: magnitudes
	logic        acc;
	logic        vld_s1, vld_s2;
	logic [31:0] at_s1, ar_s1;
	side_t       side_s1, side_s2;
	logic [46:0] prod_s2;

	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		at_s1            <= translation[31] ? (~translation + 32'd1) : translation;
		ar_s1            <= rotation[31] ? (~rotation + 32'd1) : rotation;
		side_s1.slip     <= slip_conf;
		side_s1.raw      <= raw_confidence;
		side_s1.rot_zero <= (rotation == '0);
		side_s1.tight    <= 1'b0;
		// s2: 100 cm times Q8 scale
		prod_s2          <= 47'(at_s1) * 47'(15'd25600);
		side_s2          <= side_s1;
	end

	logic [31:0] ar_s2;
	always_ff @(posedge clk) begin
		ar_s2 <= ar_s1;
	end

	// radius division, saturates at 2^24-1
	logic                d1_vld;
	logic [RADIUS_W-1:0] radius;
	logic [SW-1:0]       d1_side_raw;
	side_t               d1_side;

	trc_div #(.NW(47), .DW(32), .QW(RADIUS_W), .SW(SW)) u_div_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.num      (prod_s2),
		.den      (ar_s2),
		.in_side  (SW'(side_s2)),
		.out_valid(d1_vld),
		.quo      (radius),
		.out_side (d1_side_raw)
	);

	assign d1_side = side_t'(d1_side_raw);

	// s3: exponent argument operands
	logic        vld_s3;
	logic [24:0] den_s3;
	side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		den_s3  <= 25'(radius) + 25'(offset_q);
		side_s3 <= '{slip: d1_side.slip, raw: d1_side.raw, rot_zero: d1_side.rot_zero,
			tight: (radius <= thresh_q)};
	end

	logic              d2_vld;
	logic [XARG_W-1:0] xarg;
	logic [SW-1:0]     d2_side;

	// quotients at or above 16.0 saturate; the exp stage treats arguments at or above 12.0 as zero
	trc_div #(.NW(40), .DW(25), .QW(XARG_W), .SW(SW)) u_div_xarg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      ({gain_q, 16'd0}),
		.den      (den_s3),
		.in_side  (SW'(side_s3)),
		.out_valid(d2_vld),
		.quo      (xarg),
		.out_side (d2_side)
	);

	logic              ex_vld;
	logic [CONF_W-1:0] ex_conf;
	logic [SW-1:0]     ex_side_raw;
	side_t             ex_side;

	trc_exp #(.CONFIDENCE_MAX(CONFIDENCE_MAX), .SW(SW)) u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d2_vld),
		.x        (xarg),
		.in_side  (d2_side),
		.out_valid(ex_vld),
		.conf     (ex_conf),
		.out_side (ex_side_raw)
	);

	assign ex_side = side_t'(ex_side_raw);

	// s4: radius confidence select and slip product
	logic              vld_s4;
	logic [CONF_W-1:0] rc;
	logic              slip_pos;
	logic [46:0]       mprod_s4;
	logic [31:0]       raw_s4;

	always_comb begin
		if (ex_side.rot_zero) begin
			rc = CONF_W'(CONFIDENCE_MAX);
		end else if (ex_side.tight) begin
			rc = min_conf_q;
		end else begin
			rc = ex_conf;
		end
	end

	assign slip_pos = !ex_side.slip[31] && (ex_side.slip != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= ex_vld;
		end
	end

	always_ff @(posedge clk) begin
		mprod_s4 <= slip_pos ? (47'(rc) * 47'(ex_side.slip[30:0])) : '0;
		raw_s4   <= ex_side.raw;
	end

	// model scale: multiply by ceil(2^MSHIFT/CONFIDENCE_MAX) and shift,
	// exact for every 47-bit product
	localparam int MSHIFT = 47 + $clog2(CONFIDENCE_MAX);
	localparam longint unsigned RECIP =
		((64'd1 << MSHIFT) + 64'(CONFIDENCE_MAX) - 64'd1) / 64'(CONFIDENCE_MAX);
	localparam logic [23:0] RECIP_LO = 24'(RECIP);
	localparam logic [23:0] RECIP_HI = 24'(RECIP >> 24);

	logic        vld_s5, vld_s6, vld_s7;
	logic [47:0] pp_ll_s5, pp_lh_s5, pp_hl_s5, pp_hh_s5;
	logic [31:0] raw_s5, raw_s6, raw_s7, fin_s7;
	logic [30:0] model_s6, model_s7;
	logic [95:0] msum;
	logic [48:0] mquo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign msum = {pp_hh_s5, 48'd0} + 96'({pp_lh_s5, 24'd0}) + 96'({pp_hl_s5, 24'd0}) +
		96'(pp_ll_s5);
	assign mquo = 49'(msum >> MSHIFT);

	// s5: partial products, s6: model with saturation, s7: output register
	always_ff @(posedge clk) begin
		pp_ll_s5 <= 48'(mprod_s4[23:0]) * 48'(RECIP_LO);
		pp_lh_s5 <= 48'(mprod_s4[23:0]) * 48'(RECIP_HI);
		pp_hl_s5 <= 48'(mprod_s4[46:24]) * 48'(RECIP_LO);
		pp_hh_s5 <= 48'(mprod_s4[46:24]) * 48'(RECIP_HI);
		raw_s5   <= raw_s4;
		model_s6 <= (mquo > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : mquo[30:0];
		raw_s6   <= raw_s5;
		raw_s7   <= raw_s6;
		model_s7 <= model_s6;
		fin_s7   <= ($signed(raw_s6) < $signed({1'b0, model_s6})) ? raw_s6 :
			{1'b0, model_s6};
	end

	assign done               = vld_s7;
	assign raw_confidence_out = raw_s7;
	assign model_confidence   = model_s7;
	assign final_confidence   = fin_s7;

`ifndef SYNTHESIS
	a_fin_pick: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (final_confidence == raw_confidence_out) ||
			(final_confidence == {1'b0, model_confidence}))
		else $error("final confidence is neither raw nor model");
	a_fin_le_raw: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $signed(final_confidence) <= $signed(raw_confidence_out))
		else $error("final confidence above raw");
	a_neg_raw: assert property (@(posedge clk) disable iff (!arst_n)
		done && raw_confidence_out[31] |-> final_confidence == raw_confidence_out)
		else $error("negative raw confidence not passed through");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
`endif

endmodule
`default_nettype wire

FILE: hdl/trc_div.sv
`default_nettype none
module trc_div #(
	parameter int NW = 47,
	parameter int DW = 32,
	parameter int QW = 24,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic [SW-1:0]      out_side
);
	localparam int HW = NW - QW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [DW-1:0] rem_s  [0:QW];
	logic [QW-1:0] lo_s   [0:QW];
	logic [QW-1:0] q_s    [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic          sat_s  [0:QW];
	logic [QW:0]   vld_s;

	logic [CW-1:0] hi_ext, den_ext;

	assign hi_ext  = CW'(num[NW-1:QW]);
	assign den_ext = CW'(den);

	// quotient would not fit in QW bits: saturate to all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sat_s[0]  <= (hi_ext >= den_ext);
		rem_s[0]  <= hi_ext[DW-1:0];
		lo_s[0]   <= num[QW-1:0];
		q_s[0]    <= '0;
		den_s[0]  <= den;
		side_s[0] <= in_side;
	end

	for (genvar i = 1; i <= QW; i++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[i-1], lo_s[i-1][QW-1]};
		assign ge    = (trial >= {1'b0, den_s[i-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? DW'(trial - {1'b0, den_s[i-1]}) : trial[DW-1:0];
			lo_s[i]   <= lo_s[i-1] << 1;
			q_s[i]    <= (q_s[i-1] << 1) | QW'(ge);
			den_s[i]  <= den_s[i-1];
			sat_s[i]  <= sat_s[i-1];
			side_s[i] <= side_s[i-1];
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = sat_s[QW] ? '1 : q_s[QW];
	assign out_side  = side_s[QW];

endmodule
`default_nettype wire

FILE: hdl/trc_exp.sv
`default_nettype none
module trc_exp #(
	parameter int CONFIDENCE_MAX = trc_pkg::CONF_MAX_DEFAULT,
	parameter int SW = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [trc_pkg::XARG_W-1:0]  x,
	input  wire logic [SW-1:0]               in_side,
	output logic                             out_valid,
	output logic [trc_pkg::CONF_W-1:0]       conf,
	output logic [SW-1:0]                    out_side
);
	import trc_pkg::*;

	logic [3:0]         n;
	logic [4:0]         k;
	logic [11:0]        r;
	logic [EXP_W-1:0]   fk, fk1, dk;
	logic [28:0]        dprod;
	logic [2*EXP_W-1:0] iprod, cprod;

	logic [EXP_W-1:0] v_s1, e_s2;
	logic [3:0]       n_s1;
	logic             ovf_s1;
	logic [SW-1:0]    side_s1, side_s2, side_s3;
	logic             vld_s1, vld_s2, vld_s3;
	logic [CONF_W-1:0] conf_s3;

	assign n     = x[19:16];
	assign k     = {1'b0, x[15:12]};
	assign r     = x[11:0];
	assign fk    = frac_tab(k);
	assign fk1   = frac_tab(k + 5'd1);
	assign dk    = fk - fk1;
	assign dprod = 29'(dk) * 29'(r);
	assign iprod = 34'(int_tab(n_s1)) * 34'(v_s1);
	assign cprod = 34'(CONF_W'(CONFIDENCE_MAX)) * 34'(e_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= fk - EXP_W'(dprod >> 12);
		n_s1    <= n;
		ovf_s1  <= (n >= 4'd12);
		side_s1 <= in_side;
		e_s2    <= ovf_s1 ? '0 : iprod[32:16];
		side_s2 <= side_s1;
		conf_s3 <= cprod[31:16];
		side_s3 <= side_s2;
	end

	assign out_valid = vld_s3;
	assign conf      = conf_s3;
	assign out_side  = side_s3;

endmodule
`default_nettype wire

FILE: verif/turn_radius_confidence_unit_tb.sv
`default_nettype none
module turn_radius_confidence_unit_tb;
	import trc_pkg::*;

	localparam int CMAX = CONF_MAX_DEFAULT;
	localparam int LATENCY = 56;

	typedef struct packed {
		logic [31:0] trans;
		logic [31:0] rot;
		logic [31:0] slip;
		logic [31:0] raw;
	} snapshot_t;

	typedef struct packed {
		logic [31:0] raw_out;
		logic [30:0] model;
		logic [31:0] fin;
	} confidence_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [31:0] translation = '0;
	logic [31:0] rotation = '0;
	logic [31:0] slip_conf = '0;
	logic [31:0] raw_confidence = '0;
	logic done;
	logic [31:0] raw_confidence_out;
	logic [30:0] model_confidence;
	logic [31:0] final_confidence;

	turn_radius_confidence_unit u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .translation(translation),
		.rotation(rotation), .slip_conf(slip_conf),
		.raw_confidence(raw_confidence), .done(done),
		.raw_confidence_out(raw_confidence_out), .model_confidence(model_confidence),
		.final_confidence(final_confidence)
	);

	always #4 clk = ~clk;

	// local copy of the configuration
	logic [23:0] cfg_threshold = 24'd0;
	logic [15:0] cfg_min_conf = 16'd0;
	logic [23:0] cfg_offset = 24'd256;
	logic [23:0] cfg_gain = 24'd0;

	snapshot_t pending_snapshots[$];
	confidence_t expected_confidences[$];
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;

	function automatic logic [32:0] magnitude(logic [31:0] v);
		return v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
	endfunction

	function automatic longint unsigned exp_neg(longint unsigned x);
		longint unsigned n, f, k, r, v, a, b;
		n = x >> 16;
		f = x & 64'hFFFF;
		if (n >= 12)
			return 0;
		k = f >> 12;
		r = f & 64'hFFF;
		a = frac_tab(5'(k));
		b = frac_tab(5'(k + 1));
		v = a - (((a - b) * r) >> 12);
		return (longint'(int_tab(4'(n))) * v) >> 16;
	endfunction

	function automatic longint unsigned radius_conf(snapshot_t s);
		longint unsigned at, ar, radius, x;
		at = magnitude(s.trans);
		ar = magnitude(s.rot);
		if (ar == 0)
			return CMAX;
		radius = (at * 25600) / ar;
		if (radius > 64'hFFFFFF)
			radius = 64'hFFFFFF;
		if (radius <= cfg_threshold)
			return cfg_min_conf;
		x = (longint'(cfg_gain) << 16) / (radius + cfg_offset);
		return (CMAX * exp_neg(x)) >> 16;
	endfunction

	function automatic confidence_t predict_confidence(snapshot_t s);
		confidence_t c;
		longint unsigned rc, model;
		longint signed slip, raw, fin;
		rc = radius_conf(s);
		slip = longint'($signed(s.slip));
		raw = longint'($signed(s.raw));
		model = 0;
		if (rc > 0 && slip > 0) begin
			model = (rc * slip) / CMAX;
			if (model > 64'h7FFFFFFF)
				model = 64'h7FFFFFFF;
		end
		fin = (raw < longint'(model)) ? raw : longint'(model);
		c.raw_out = s.raw;
		c.model = model[30:0];
		c.fin = fin[31:0];
		return c;
	endfunction

	// driver: bursts of transactions with random gaps
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_confidences.push_back(predict_confidence(
				{translation, rotation, slip_conf, raw_confidence}));
		end
		if (start && busy) begin
			// hold the current transaction
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_snapshots.size() > 0) begin
			snapshot_t s;
			s = pending_snapshots.pop_front();
			translation <= s.trans;
			rotation <= s.rot;
			slip_conf <= s.slip;
			raw_confidence <= s.raw;
			start <= 1'b1;
			if (burst_left > 0) begin
				burst_left <= burst_left - 1;
			end else begin
				burst_left <= $urandom_range(0, 20);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_confidences.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				confidence_t e;
				e = expected_confidences.pop_front();
				if (raw_confidence_out !== e.raw_out) begin
					$error("raw_confidence_out exp %0h got %0h", e.raw_out, raw_confidence_out);
					errors++;
				end
				if (model_confidence !== e.model) begin
					$error("model_confidence exp %0h got %0h", e.model, model_confidence);
					errors++;
				end
				if (final_confidence !== e.fin) begin
					$error("final_confidence exp %0h got %0h", e.fin, final_confidence);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 4'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_THRESHOLD: cfg_threshold = value[23:0];
			REG_MIN_CONF:  cfg_min_conf = value[15:0];
			REG_OFFSET:    cfg_offset = value[23:0];
			REG_GAIN:      cfg_gain = value[23:0];
			default:       ;
		endcase
	endtask

	task automatic drain();
		while (pending_snapshots.size() > 0 || start || expected_confidences.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_snapshot(logic [31:0] t, logic [31:0] r, logic [31:0] s,
		logic [31:0] w);
		pending_snapshots.push_back({t, r, s, w});
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 4) - 2;
			3: return $urandom_range(0, 4096);
			default: return $urandom();
		endcase
	endfunction

	task automatic add_random(int count);
		logic [31:0] t, r, s, w;
		repeat (count) begin
			t = ($urandom_range(0, 3) == 0) ? rand_word() :
				32'($signed($urandom_range(0, 2000000)) - 1000000);
			r = ($urandom_range(0, 3) == 0) ? rand_word() :
				32'($signed($urandom_range(0, 400000)) - 200000);
			if ($urandom_range(0, 15) == 0)
				r = 32'd0;
			s = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 2048);
			w = ($urandom_range(0, 2) == 0) ? rand_word() : $urandom_range(0, 2048);
			add_snapshot(t, r, s, w);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, zero rotation, extremes, slip signs
		add_snapshot(32'd1000, 32'd0, 32'd1000, 32'h7FFF_FFFF);
		add_snapshot(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_snapshot(32'h7FFF_FFFF, 32'd1, 32'd5, 32'h8000_0000);
		add_snapshot(32'd0, 32'h8000_0000, 32'd0, 32'd0);
		add_snapshot(32'd100, 32'd7, 32'hFFFF_FFFF, 32'd500);
		add_snapshot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3000, 32'hFFFF_FFFF);
		drain();

		// large gain: exponent runs past the table
		write_reg(REG_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_OFFSET, 32'd0);
		add_snapshot(32'd10, 32'd1000, 32'd1024, 32'd2000);
		add_snapshot(32'h7FFF_FFFF, 32'd1, 32'd1024, 32'd2000);
		add_snapshot(32'd5000, 32'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		drain();

		// min confidence above max saturates the model
		write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
		write_reg(REG_MIN_CONF, 32'hFFFF_FFFF);
		add_snapshot(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_snapshot(32'd1, 32'd1, 32'd1, 32'h8000_0000);
		add_snapshot(32'd1, 32'd0, 32'h7FFF_FFFF, 32'd7);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_THRESHOLD, (phase == 0) ? 32'd0 : $urandom_range(0, 300000));
			write_reg(REG_MIN_CONF, (phase == 1) ? 32'hFFFF : $urandom_range(0, 1100));
			write_reg(REG_OFFSET, (phase == 2) ? 32'hFF_FFFF : $urandom_range(0, 100000));
			write_reg(REG_GAIN, (phase == 3) ? 32'h0 : (phase == 4) ? 32'hFF_FFFF :
				$urandom_range(0, 2000000));
			add_random(305);
			drain();
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_confidences.size() == 0) begin
			$display("turn_radius_confidence_unit_tb: PASS");
		end else begin
			$display("turn_radius_confidence_unit_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("turn_radius_confidence_unit_tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
hdl/trc_pkg.sv
hdl/trc_div.sv
hdl/trc_exp.sv
hdl/turn_radius_confidence_unit.sv
verif/turn_radius_confidence_unit_tb.sv
